FILE: sv/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types, sizes and helpers for the binary heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CAPACITY   = 64;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int COUNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W      = ADDR_W + 2;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic [COUNT_W-1:0]           count_t;

  typedef enum logic [0:0] {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_ISSUE,
    ST_UP_CMP,
    ST_DN_LOAD,
    ST_DN_ISSUE,
    ST_DN_CMP,
    ST_OUT
  } state_t;

  typedef struct packed {
    func_t func;
    word_t value;
  } req_t;

  typedef struct packed {
    word_t  removed_value;
    word_t  top_value;
    logic   is_empty;
    count_t entry_count;
    err_t   error_code;
  } rsp_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    addr_t raddr_a;
    addr_t raddr_b;
  } mem_req_t;

  // True when a ranks strictly below b: mode 0 serves largest first.
  function automatic logic worse(input word_t a, input word_t b, input logic mode);
    worse = mode ? (a > b) : (a < b);
  endfunction

endpackage

FILE: sv/bhpq_store.sv
// ----------------------------------------------------------------------------
// bhpq_store
// Heap entry memory: one write port, two registered read ports, and a
// mirror of the root entry.
// ----------------------------------------------------------------------------
module bhpq_store
  import bhpq_pkg::*;
(
  input  logic     clk,
  input  mem_req_t mem_req,
  output word_t    rdata_a,
  output word_t    rdata_b,
  output word_t    root
);

  word_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    rdata_a <= mem[mem_req.raddr_a];
    rdata_b <= mem[mem_req.raddr_b];
  end

  always_ff @(posedge clk) begin
    if (mem_req.we && (mem_req.waddr == '0)) begin
      root <= mem_req.wdata;
    end
  end

endmodule

FILE: sv/binary_heap_priority_queue_core.sv
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_core
// Binary heap priority queue of signed words with push and pop.
// ----------------------------------------------------------------------------
// Request channel req_valid / req_stall / req_data carries one item: func
// (push or pop) and value. Response channel rsp_valid / rsp_stall / rsp_data
// returns one item per request: removed value, new top, empty flag, count
// and error code. cfg_wr_en / cfg_wr_data write order_mode; the user must do so
// only while idle, as the block itself does not enforce it. One item is in
// work at a time. The entries live in a memory with registered read ports;
// each heap level is a read, then a compare and write back. A push climbs
// until it stops or reaches the root, a pop descends until it stops or
// reaches a leaf, and errored items go straight to the output step. The next
// item can be accepted in the cycle after a result is loaded; req_stall is
// high while an item is in work.
// The response register lets the next request enter while a result waits;
// a stalled response holds and the following item waits at its last step.
// Reset empties the heap, sets largest-first order and drops any pending
// response; memory contents are not cleared.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_core
  import bhpq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  state_t   state, state_next;
  count_t   cnt, cnt_next;
  addr_t    pos, pos_next;
  word_t    cur, cur_next;
  word_t    removed, removed_next;
  err_t     err, err_next;
  logic     order_mode;
  logic     rsp_valid_next;
  rsp_t     rsp_next;
  mem_req_t mem_req;
  word_t    rdata_a, rdata_b, root;

  logic             accept, slot_free, is_full;
  addr_t            parent;
  logic [IDX_W-1:0] left_idx, right_idx, cnt_ext;
  logic             has_left, has_right;
  logic             take_l, take_r, move_down;
  word_t            best_v, child_v;
  logic [IDX_W-1:0] child_idx;

  bhpq_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b),
    .root    (root)
  );

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && (state == ST_IDLE);
  assign slot_free = !rsp_valid || !rsp_stall;
  assign is_full   = (cnt == COUNT_W'(CAPACITY));

  assign parent    = addr_t'((pos - 1'b1) >> 1);
  assign left_idx  = IDX_W'({pos, 1'b1});
  assign right_idx = left_idx + 1'b1;
  assign cnt_ext   = IDX_W'(cnt);
  assign has_left  = left_idx < cnt_ext;
  assign has_right = right_idx < cnt_ext;

  assign take_l    = worse(cur, rdata_a, order_mode);
  assign best_v    = take_l ? rdata_a : cur;
  assign take_r    = has_right && worse(best_v, rdata_b, order_mode);
  assign move_down = take_l || take_r;
  assign child_v   = take_r ? rdata_b : rdata_a;
  assign child_idx = take_r ? right_idx : left_idx;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_data.func == FUNC_PUSH) begin
            state_next = is_full ? ST_OUT : ST_UP_ISSUE;
          end else begin
            state_next = (cnt == '0) ? ST_OUT : ST_DN_LOAD;
          end
        end
      end
      ST_UP_ISSUE: state_next = (pos == '0) ? ST_OUT : ST_UP_CMP;
      ST_UP_CMP:   state_next = worse(cur, rdata_a, order_mode) ? ST_OUT : ST_UP_ISSUE;
      ST_DN_LOAD:  state_next = ST_DN_ISSUE;
      ST_DN_ISSUE: state_next = has_left ? ST_DN_CMP : ST_OUT;
      ST_DN_CMP:   state_next = move_down ? ST_DN_ISSUE : ST_OUT;
      ST_OUT:      state_next = slot_free ? ST_IDLE : ST_OUT;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_next       = cnt;
    pos_next       = pos;
    cur_next       = cur;
    removed_next   = removed;
    err_next       = err;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp_data;
    mem_req        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          err_next     = ERR_OK;
          removed_next = '0;
          if (req_data.func == FUNC_PUSH) begin
            if (is_full) begin
              err_next = ERR_FULL;
            end else begin
              pos_next = addr_t'(cnt);
              cur_next = req_data.value;
              cnt_next = cnt + 1'b1;
            end
          end else begin
            if (cnt == '0) begin
              err_next = ERR_EMPTY;
            end else begin
              removed_next    = root;
              cnt_next        = cnt - 1'b1;
              pos_next        = '0;
              mem_req.raddr_a = addr_t'(cnt - 1'b1);
            end
          end
        end
      end
      ST_UP_ISSUE: begin
        if (pos == '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos;
          mem_req.wdata = cur;
        end else begin
          mem_req.raddr_a = parent;
        end
      end
      ST_UP_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos;
        if (worse(cur, rdata_a, order_mode)) begin
          mem_req.wdata = cur;
        end else begin
          mem_req.wdata = rdata_a;
          pos_next      = parent;
        end
      end
      ST_DN_LOAD: begin
        cur_next = rdata_a;
      end
      ST_DN_ISSUE: begin
        if (has_left) begin
          mem_req.raddr_a = addr_t'(left_idx);
          mem_req.raddr_b = has_right ? addr_t'(right_idx) : addr_t'(left_idx);
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos;
          mem_req.wdata = cur;
        end
      end
      ST_DN_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos;
        if (move_down) begin
          mem_req.wdata = child_v;
          pos_next      = addr_t'(child_idx);
        end else begin
          mem_req.wdata = cur;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          rsp_valid_next         = 1'b1;
          rsp_next.removed_value = removed;
          rsp_next.top_value     = (cnt != '0) ? root : '0;
          rsp_next.is_empty      = (cnt == '0);
          rsp_next.entry_count   = cnt;
          rsp_next.error_code    = err;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      order_mode <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      rsp_valid <= rsp_valid_next;
      if (cfg_wr_en) begin
        order_mode <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    cur      <= cur_next;
    removed  <= removed_next;
    err      <= err_next;
    rsp_data <= rsp_next;
  end

endmodule
